@@ src/tap_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tap_pkg: shared types and constants of the tile average pixelate unit
// Channel sum and average types, register indexes.
// ----------------------------------------------------------------------------
package tap_pkg;

    localparam int SUM_W = 20;   // per-channel tile sum
    localparam int AVG_W = 8;    // per-channel average
    localparam int CFG_W = 13;   // widest register
    localparam int IDX_W = 3;    // register index

    typedef logic [IDX_W-1:0] reg_idx_t;
    localparam reg_idx_t REG_IMAGE_WIDTH  = 3'd0;
    localparam reg_idx_t REG_IMAGE_HEIGHT = 3'd1;
    localparam reg_idx_t REG_TILE_SIZE    = 3'd2;
    localparam reg_idx_t REG_FORCE_OPAQUE = 3'd3;

    typedef struct packed {
        logic [SUM_W-1:0] alpha;
        logic [SUM_W-1:0] blue;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] red;
    } sums_t;

    typedef struct packed {
        logic [AVG_W-1:0] alpha;
        logic [AVG_W-1:0] blue;
        logic [AVG_W-1:0] green;
        logic [AVG_W-1:0] red;
    } quot_t;

endpackage

@@ src/tile_average_pixelate_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_average_pixelate_unit: block-average mosaic of an RGBA frame
// Sums pixels per square tile and emits each tile's truncated mean.
// ----------------------------------------------------------------------------
// Pixels enter in raster order on the slave stream. Each pixel is handled as a
// registered read of the tile column's running sums from the accumulator
// memory (one read port), followed by an add and write back. A pixel that
// closes a tile (bottom-right, partial edge tiles included) also starts the
// four-channel divider, which produces one quotient bit per cycle; the slave
// stream stays not ready until that average is in the output register. The
// average beat waits in an output register, so input continues while it is
// pending. Partial edge tiles are divided by their real pixel count. The
// first pixel of a tile loads the sums, so the memory needs no clearing pass
// after reset. A write to image_width, image_height or tile_size restarts the frame.
// ----------------------------------------------------------------------------
module tile_average_pixelate_unit #(
    parameter int MAX_WIDTH = 4096,
    parameter int MAX_TILE  = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  tap_pkg::reg_idx_t         cfg_index,
    input  logic [tap_pkg::CFG_W-1:0] cfg_data,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [31:0]               s_tdata,  // pix_red, pix_green, pix_blue, pix_alpha
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [55:0]               m_tdata,  // avg_red, avg_green, avg_blue, avg_alpha,
                                                // tile_col, tile_row
    output logic                      m_tlast   // frame_done
);

    localparam int PW    = $clog2(MAX_WIDTH);
    localparam int TW    = $clog2(MAX_TILE);
    localparam int CNT_W = 2 * (TW + 1);

    typedef enum logic [1:0] {ST_IDLE, ST_RMW, ST_DIV, ST_HOLD} state_t;

    state_t                   state_reg;
    logic [tap_pkg::CFG_W-1:0] width_reg;
    logic [tap_pkg::CFG_W-1:0] height_reg;
    logic [6:0]               tile_reg;
    logic                     opaque_reg;

    logic [PW-1:0]            col_reg, row_reg, tc_reg, tr_reg;
    logic [TW-1:0]            itc_reg, itr_reg;
    logic [31:0]              pix_reg;
    logic [11:0]              pend_col_reg, pend_row_reg;
    logic                     pend_last_reg;

    logic                     out_valid_reg;
    logic [55:0]              out_data_reg;
    logic                     out_last_reg;

    tap_pkg::sums_t           mem [MAX_WIDTH];
    tap_pkg::sums_t           rd_reg;
    tap_pkg::sums_t           sums_next;

    logic [PW:0]              w_eff, h_eff;
    logic [TW:0]              ts_eff;
    logic                     last_col, last_row, itc_end, itr_end;
    logic                     first_pix, tile_done, s_acc, slot_free;
    logic [CNT_W-1:0]         cnt;
    logic                     div_start, div_done;
    tap_pkg::quot_t           quot;

    // Clamp the geometry registers into their usable ranges.
    always_comb
    begin
        if (width_reg == '0)
            w_eff = (PW+1)'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            w_eff = (PW+1)'(MAX_WIDTH);
        else
            w_eff = (PW+1)'(width_reg);

        if (height_reg == '0)
            h_eff = (PW+1)'(1);
        else if (32'(height_reg) > MAX_WIDTH)
            h_eff = (PW+1)'(MAX_WIDTH);
        else
            h_eff = (PW+1)'(height_reg);

        if (tile_reg == '0)
            ts_eff = (TW+1)'(1);
        else if (32'(tile_reg) > MAX_TILE)
            ts_eff = (TW+1)'(MAX_TILE);
        else
            ts_eff = (TW+1)'(tile_reg);
    end

    assign last_col  = ({1'b0, col_reg} == w_eff - 1'b1);
    assign last_row  = ({1'b0, row_reg} == h_eff - 1'b1);
    assign itc_end   = ({1'b0, itc_reg} == ts_eff - 1'b1);
    assign itr_end   = ({1'b0, itr_reg} == ts_eff - 1'b1);
    assign first_pix = (itc_reg == '0) && (itr_reg == '0);
    assign tile_done = (last_col || itc_end) && (last_row || itr_end);
    assign cnt       = CNT_W'({1'b0, itc_reg} + 1'b1) * CNT_W'({1'b0, itr_reg} + 1'b1);

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign slot_free = !out_valid_reg || m_tready;
    assign div_start = (state_reg == ST_RMW) && tile_done;

    // Load on a tile's first pixel, accumulate otherwise.
    always_comb
    begin
        if (first_pix)
        begin
            sums_next.red   = tap_pkg::SUM_W'(pix_reg[7:0]);
            sums_next.green = tap_pkg::SUM_W'(pix_reg[15:8]);
            sums_next.blue  = tap_pkg::SUM_W'(pix_reg[23:16]);
            sums_next.alpha = tap_pkg::SUM_W'(pix_reg[31:24]);
        end
        else
        begin
            sums_next.red   = rd_reg.red   + tap_pkg::SUM_W'(pix_reg[7:0]);
            sums_next.green = rd_reg.green + tap_pkg::SUM_W'(pix_reg[15:8]);
            sums_next.blue  = rd_reg.blue  + tap_pkg::SUM_W'(pix_reg[23:16]);
            sums_next.alpha = rd_reg.alpha + tap_pkg::SUM_W'(pix_reg[31:24]);
        end
    end

    // Accumulator memory: read on accept, write back in the next cycle.
    always_ff @(posedge clk)
    begin
        if (s_acc)
            rd_reg <= mem[tc_reg];
        if (state_reg == ST_RMW)
            mem[tc_reg] <= sums_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_acc)
            pix_reg <= s_tdata;
        if (state_reg == ST_RMW)
        begin
            pend_col_reg  <= 12'(tc_reg);
            pend_row_reg  <= 12'(tr_reg);
            pend_last_reg <= last_col && last_row;
        end
    end

    tap_div #(
        .CNT_W (CNT_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .cnt   (cnt),
        .sums  (sums_next),
        .done  (div_done),
        .quot  (quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            width_reg     <= tap_pkg::CFG_W'(640);
            height_reg    <= tap_pkg::CFG_W'(480);
            tile_reg      <= 7'd30;
            opaque_reg    <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            tc_reg        <= '0;
            tr_reg        <= '0;
            itc_reg       <= '0;
            itr_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && m_tready)
                out_valid_reg <= 1'b0;

            // Geometry writes restart the frame; opacity applies at once.
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    tap_pkg::REG_IMAGE_WIDTH,
                    tap_pkg::REG_IMAGE_HEIGHT,
                    tap_pkg::REG_TILE_SIZE:
                    begin
                        if (cfg_index == tap_pkg::REG_IMAGE_WIDTH)
                            width_reg <= cfg_data;
                        else if (cfg_index == tap_pkg::REG_IMAGE_HEIGHT)
                            height_reg <= cfg_data;
                        else
                            tile_reg <= cfg_data[6:0];
                        col_reg <= '0;
                        row_reg <= '0;
                        tc_reg  <= '0;
                        tr_reg  <= '0;
                        itc_reg <= '0;
                        itr_reg <= '0;
                    end
                    tap_pkg::REG_FORCE_OPAQUE: opaque_reg <= cfg_data[0];
                    default: ;
                endcase
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (s_acc)
                        state_reg <= ST_RMW;
                end
                ST_RMW:
                begin
                    // Advance the raster and tile positions.
                    if (last_col)
                    begin
                        col_reg <= '0;
                        itc_reg <= '0;
                        tc_reg  <= '0;
                        if (last_row)
                        begin
                            row_reg <= '0;
                            itr_reg <= '0;
                            tr_reg  <= '0;
                        end
                        else
                        begin
                            row_reg <= row_reg + 1'b1;
                            if (itr_end)
                            begin
                                itr_reg <= '0;
                                tr_reg  <= tr_reg + 1'b1;
                            end
                            else
                                itr_reg <= itr_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        col_reg <= col_reg + 1'b1;
                        if (itc_end)
                        begin
                            itc_reg <= '0;
                            tc_reg  <= tc_reg + 1'b1;
                        end
                        else
                            itc_reg <= itc_reg + 1'b1;
                    end
                    state_reg <= tile_done ? ST_DIV : ST_IDLE;
                end
                ST_DIV, ST_HOLD:
                begin
                    if ((div_done || state_reg == ST_HOLD) && slot_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {pend_row_reg, pend_col_reg,
                                          opaque_reg ? 8'hFF : quot.alpha,
                                          quot.blue, quot.green, quot.red};
                        out_last_reg  <= pend_last_reg;
                        state_reg     <= ST_IDLE;
                    end
                    else if (div_done)
                        state_reg <= ST_HOLD;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

@@ src/tap_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tap_div: four-channel restoring divider
// Divides four tile sums by one pixel count, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tap_div #(
    parameter int CNT_W = 14
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [CNT_W-1:0]  cnt,
    input  tap_pkg::sums_t    sums,
    output logic              done,
    output tap_pkg::quot_t    quot
);

    localparam int DW = CNT_W + tap_pkg::SUM_W;
    localparam int SW = $clog2(tap_pkg::AVG_W);

    logic [3:0][tap_pkg::SUM_W-1:0] rem_reg;
    logic [3:0][tap_pkg::AVG_W-1:0] q_reg;
    logic [DW-1:0]                  dvs_reg;
    logic [SW-1:0]                  step_reg;
    logic                           active_reg;
    logic                           done_reg;
    logic [3:0][tap_pkg::SUM_W-1:0] sum_in;

    assign sum_in = {sums.alpha, sums.blue, sums.green, sums.red};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            step_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                active_reg <= 1'b1;
                step_reg   <= SW'(tap_pkg::AVG_W - 1);
            end
            else if (active_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
            end
        end
    end

    // Datapath: compare each remainder with the shifted divisor, subtract on fit.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= sum_in;
            q_reg   <= '0;
            dvs_reg <= DW'(cnt) << (tap_pkg::AVG_W - 1);
        end
        else if (active_reg)
        begin
            dvs_reg <= dvs_reg >> 1;
            for (int i = 0; i < 4; i++)
            begin
                if (DW'(rem_reg[i]) >= dvs_reg)
                begin
                    rem_reg[i] <= rem_reg[i] - tap_pkg::SUM_W'(dvs_reg);
                    q_reg[i]   <= {q_reg[i][tap_pkg::AVG_W-2:0], 1'b1};
                end
                else
                begin
                    q_reg[i]   <= {q_reg[i][tap_pkg::AVG_W-2:0], 1'b0};
                end
            end
        end
    end

    assign done       = done_reg;
    assign quot.red   = q_reg[0];
    assign quot.green = q_reg[1];
    assign quot.blue  = q_reg[2];
    assign quot.alpha = q_reg[3];

endmodule

@@ src/tap_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tap_checker: port-level checks of the tile average pixelate unit
// Watches the stream ports and flags ordering and hold violations.
// ----------------------------------------------------------------------------
module tap_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,
    input  logic        m_tlast
);

    // One pixel in flight: the block is busy right after a beat.
    a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken on consecutive cycles");

    // An average needs the accumulate and divide steps first.
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result appeared right after a pixel beat");

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output beat dropped while stalled");

    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("output beat changed while stalled");

endmodule

bind tile_average_pixelate_unit tap_checker u_tap_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench of the tile average pixelate unit
// Streams RGBA frames through the block under several geometries and compares
// every tile average beat with a cycle-free software predictor.
// ----------------------------------------------------------------------------
module tb;

    typedef struct packed {
        logic       done;
        logic [11:0] row;
        logic [11:0] col;
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] g;
        logic [7:0] r;
    } tile_avg_t;

    typedef struct {
        logic [31:0] pix;
        logic        known;   // expected beat typed in below
        tile_avg_t   avg;
    } row_t;

    localparam int LIMIT = 2000000;
    localparam int MAX_W_TB = 4096;
    localparam tap_pkg::reg_idx_t REG_UNKNOWN = 3'd7;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    tap_pkg::reg_idx_t cfg_index;
    logic [tap_pkg::CFG_W-1:0] cfg_data;
    logic s_tvalid;
    logic s_tready;
    logic [31:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [55:0] m_tdata;
    logic m_tlast;

    // predictor state
    int unsigned geo_w, geo_h, geo_ts, opaque;
    logic [19:0] acc_r [MAX_W_TB];
    logic [19:0] acc_g [MAX_W_TB];
    logic [19:0] acc_b [MAX_W_TB];
    logic [19:0] acc_a [MAX_W_TB];
    int unsigned px, py, tx, ty;

    tile_avg_t avg_queue[$];
    int errors;
    int beats_seen;
    int cycles;
    int frames_seen;

    tile_average_pixelate_unit dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Clear positions and sums; the block itself resets only its positions on a geometry write.
    function automatic void restart_tiles();
        for (int i = 0; i < MAX_W_TB; i++)
        begin
            acc_r[i] = '0; acc_g[i] = '0; acc_b[i] = '0; acc_a[i] = '0;
        end
        px = 0; py = 0; tx = 0; ty = 0;
    endfunction

    function automatic int unsigned clamp(int unsigned v, int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // Mirror a register write into the predictor.
    function automatic void predict_config(tap_pkg::reg_idx_t idx,
                                           logic [tap_pkg::CFG_W-1:0] val);
        case (idx)
            tap_pkg::REG_IMAGE_WIDTH:  begin geo_w = 32'(val); restart_tiles(); end
            tap_pkg::REG_IMAGE_HEIGHT: begin geo_h = 32'(val); restart_tiles(); end
            tap_pkg::REG_TILE_SIZE:    begin geo_ts = 32'(val[6:0]); restart_tiles(); end
            tap_pkg::REG_FORCE_OPAQUE: opaque = 32'(val[0]);
            default: ;
        endcase
    endfunction

    // Accumulate one pixel; return 1 and the tile average when a tile closes.
    function automatic bit tile_average(logic [31:0] pix, output tile_avg_t res);
        int unsigned w, h, ts, tc, tr, cnt;
        bit lc, lr;
        w = clamp(geo_w, 4096);
        h = clamp(geo_h, 4096);
        ts = clamp(geo_ts, 64);
        res = '0;
        if (px >= w || py >= h || tx >= ts || ty >= ts) restart_tiles();
        tc = px / ts;
        tr = py / ts;
        if (tx == 0 && ty == 0)
        begin
            acc_r[tc] = 20'(pix[7:0]); acc_g[tc] = 20'(pix[15:8]);
            acc_b[tc] = 20'(pix[23:16]); acc_a[tc] = 20'(pix[31:24]);
        end
        else
        begin
            acc_r[tc] += 20'(pix[7:0]); acc_g[tc] += 20'(pix[15:8]);
            acc_b[tc] += 20'(pix[23:16]); acc_a[tc] += 20'(pix[31:24]);
        end
        lc = (px == w - 1);
        lr = (py == h - 1);
        tile_average = 0;
        if ((lc || tx == ts - 1) && (lr || ty == ts - 1))
        begin
            cnt = (tx + 1) * (ty + 1);
            res.r = 8'(acc_r[tc] / cnt);
            res.g = 8'(acc_g[tc] / cnt);
            res.b = 8'(acc_b[tc] / cnt);
            res.a = (opaque != 0) ? 8'hFF : 8'(acc_a[tc] / cnt);
            res.col = 12'(tc);
            res.row = 12'(tr);
            res.done = lc && lr;
            tile_average = 1;
        end
        if (lc)
        begin
            px = 0; tx = 0;
            if (lr)
            begin
                py = 0; ty = 0;
            end
            else
            begin
                py++;
                ty = (ty == ts - 1) ? 0 : ty + 1;
            end
        end
        else
        begin
            px++;
            tx = (tx == ts - 1) ? 0 : tx + 1;
        end
    endfunction

    // Receiver: stall on its own pattern and check every beat.
    always @(posedge clk)
    begin
        tile_avg_t got, want;
        cycles <= cycles + 1;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = tile_avg_t'({m_tlast, m_tdata});
            beats_seen <= beats_seen + 1;
            if (got.done) frames_seen <= frames_seen + 1;
            if (avg_queue.size() == 0)
            begin
                $display("%0t: unexpected beat %h", $time, got);
                errors <= errors + 1;
            end
            else
            begin
                want = avg_queue.pop_front();
                if (got !== want)
                begin
                    $display("%0t: mismatch expected %h actual %h", $time, want, got);
                    errors <= errors + 1;
                end
            end
        end
    end

    initial
    begin
        int stall_mode;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            stall_mode = (cycles / 3000) % 3;
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= ((cycles % 7) < 3);
            endcase
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (cycles > LIMIT)
            begin
                $display("timeout after %0d cycles", cycles);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Send one pixel beat, hold until accepted, queue its prediction.
    task automatic send_pixel(logic [31:0] pix, bit known, tile_avg_t typed);
        tile_avg_t res;
        bit got;
        s_tdata  <= pix;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        got = tile_average(pix, res);
        if (got)
        begin
            if (known && res !== typed)
                $display("%0t: predictor disagrees with table: %h vs %h", $time, typed, res);
            avg_queue.push_back(known ? typed : res);
        end
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (avg_queue.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    // Write one register with the block idle.
    task automatic write_reg(tap_pkg::reg_idx_t idx, logic [tap_pkg::CFG_W-1:0] val);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        predict_config(idx, val);
    endtask

    task automatic set_geometry(int w, int h, int ts, int op);
        write_reg(tap_pkg::REG_IMAGE_WIDTH, tap_pkg::CFG_W'(w));
        write_reg(tap_pkg::REG_IMAGE_HEIGHT, tap_pkg::CFG_W'(h));
        write_reg(tap_pkg::REG_TILE_SIZE, tap_pkg::CFG_W'(ts));
        write_reg(tap_pkg::REG_FORCE_OPAQUE, tap_pkg::CFG_W'(op));
    endtask

    function automatic logic [31:0] rand_pixel();
        case ($urandom_range(0, 5))
            0: return 32'hFFFFFFFF;
            1: return 32'h00000000;
            default: return $urandom;
        endcase
    endfunction

    // Random stimulus in bursts with gaps under the current geometry.
    task automatic random_pixels(int count);
        tile_avg_t none;
        int burst;
        none = '0;
        while (count > 0)
        begin
            burst = $urandom_range(1, 40);
            for (int i = 0; i < burst && count > 0; i++, count--)
                send_pixel(rand_pixel(), 0, none);
            if ($urandom_range(0, 2) == 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge clk);
            end
        end
    endtask

    row_t dir_rows[$];

    initial
    begin
        tile_avg_t none;
        row_t rw;
        none = '0;
        errors = 0;
        beats_seen = 0;
        frames_seen = 0;
        cycles = 0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = tap_pkg::REG_IMAGE_WIDTH;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        geo_w = 640; geo_h = 480; geo_ts = 30; opaque = 0;
        restart_tiles();
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: 1x1 tiles on a 2x2 image give each pixel back as its tile.
        set_geometry(2, 2, 1, 0);
        rw.known = 1'b1;
        rw.pix = 32'hFFFFFFFF;
        rw.avg = '{1'b0, 12'd0, 12'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        dir_rows.push_back(rw);
        rw.pix = 32'h00000000;
        rw.avg = '{1'b0, 12'd0, 12'd1, 8'h00, 8'h00, 8'h00, 8'h00};
        dir_rows.push_back(rw);
        rw.pix = 32'h80402010;
        rw.avg = '{1'b0, 12'd1, 12'd0, 8'h80, 8'h40, 8'h20, 8'h10};
        dir_rows.push_back(rw);
        rw.pix = 32'h01020304;
        rw.avg = '{1'b1, 12'd1, 12'd1, 8'h01, 8'h02, 8'h03, 8'h04};
        dir_rows.push_back(rw);
        foreach (dir_rows[i]) send_pixel(dir_rows[i].pix, dir_rows[i].known, dir_rows[i].avg);

        // Directed: partial edge tiles on 3x3 with tile 2, alpha forced opaque.
        set_geometry(3, 3, 2, 1);
        for (int i = 0; i < 9; i++) send_pixel(i[0] ? 32'hFFFFFFFF : 32'h00000000, 0, none);
        // Zero geometry clamps to 1; oversize tile clamps to 64.
        set_geometry(0, 0, 0, 0);
        send_pixel(32'h55AA33CC, 1, '{1'b1, 12'd0, 12'd0, 8'h55, 8'hAA, 8'h33, 8'hCC});
        set_geometry(5, 2, 127, 0);
        for (int i = 0; i < 10; i++) send_pixel(32'hFFFFFFFF, 0, none);
        // Unknown register index leaves everything alone.
        write_reg(REG_UNKNOWN, 13'h1FFF);
        for (int i = 0; i < 10; i++) send_pixel(rand_pixel(), 0, none);

        // Random phases over several geometries.
        for (int ph = 0; ph < 12; ph++)
        begin
            case (ph)
                0: set_geometry(1, 1, 1, 0);
                1: set_geometry(64, 4, 64, 1);
                2: set_geometry(4096, 1, 64, 0);
                3: set_geometry(1, 70, 64, 0);
                default: set_geometry($urandom_range(1, 40), $urandom_range(1, 20),
                                      $urandom_range(1, 16), $urandom_range(0, 1));
            endcase
            random_pixels(ph == 2 ? 1000 : (ph == 1 ? 300 : 70));
            if (ph == 6)
            begin
                // Hold off until every pending average is out.
                s_tvalid <= 1'b0;
                while (avg_queue.size() != 0) @(negedge clk);
                // Restart mid-frame with a tile size write.
                write_reg(tap_pkg::REG_TILE_SIZE, tap_pkg::CFG_W'($urandom_range(1, 8)));
                random_pixels(100);
            end
        end
        drain();
        repeat (50) @(negedge clk);

        $display("Covered %0d tile averages and %0d completed frames over 16 geometries",
                 beats_seen, frames_seen);
        $display("including clamped, partial-tile, opaque and mid-frame restart cases");
        if (errors == 0 && avg_queue.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
